>>> hw/rtl/flook_pkg.sv
// Package of the F-LOOK track request scheduler: field widths, result codes,
// stored entry layout, controller states, datapath commands and status.
// Depends on nothing.
`default_nettype none
package flook_pkg;

  localparam int TRACK_W = 16;
  localparam int TAG_W   = 8;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_DROPPED = 2'd1,
    ST_GRANTED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_ADD_RD,
    S_ADD_CMP,
    S_SCAN_RD,
    S_SCAN_EVAL,
    S_PICK,
    S_GRAB,
    S_SHIFT,
    S_SHIFT_WR,
    S_FIN
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DROP,
    CMD_EMPTY,
    CMD_ADD_INIT,
    CMD_ADD_RD,
    CMD_ADD_MOVE,
    CMD_ADD_PUT,
    CMD_SWAP,
    CMD_SCAN_INIT,
    CMD_SCAN_RD,
    CMD_SCAN_EVAL,
    CMD_PICK,
    CMD_GRAB,
    CMD_SH_RD,
    CMD_SH_WR
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic finish;
    logic shift_end;
  } dp_ctl_t;

  typedef struct packed {
    logic is_get;
    logic pend_full;
    logic pend_empty;
    logic act_empty;
    logic idx_zero;
    logic move_up;
    logic scan_last;
    logic sh_done;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/flook_req_if.sv
// Request channel of the scheduler: valid/ready handshake with an add or get item.
// Depends on flook_pkg for the field widths.
`default_nettype none
interface flook_req_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [flook_pkg::TRACK_W-1:0] track;
  logic [flook_pkg::TAG_W-1:0]   tag;
  logic [flook_pkg::TRACK_W-1:0] head_position;
  logic                         direction_up;

  modport source (output valid, operation, track, tag, head_position, direction_up,
                  input ready);
  modport sink (input valid, operation, track, tag, head_position, direction_up,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/flook_rsp_if.sv
// Result channel of the scheduler: valid/ready handshake with one result item.
// Depends on flook_pkg for the field widths.
`default_nettype none
interface flook_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [flook_pkg::TRACK_W-1:0] granted_track;
  logic [flook_pkg::TAG_W-1:0]   granted_tag;

  modport source (output valid, status, granted_track, granted_tag, input ready);
  modport sink (input valid, status, granted_track, granted_tag, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/flook_datapath.sv
// Datapath of the scheduler: two request banks that swap roles, counts, scan
// registers and the output register. Driven by flook_ctrl; depends on flook_pkg.
`default_nettype none
module flook_datapath #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire                           clk,
  input  wire                           rst,
  input  flook_pkg::dp_ctl_t            ctl,
  output flook_pkg::dp_stat_t           stat,
  input  wire                           in_operation,
  input  wire [flook_pkg::TRACK_W-1:0]  in_track,
  input  wire [flook_pkg::TAG_W-1:0]    in_tag,
  input  wire [flook_pkg::TRACK_W-1:0]  in_head,
  input  wire                           in_up,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [1:0]                    out_status,
  output logic [flook_pkg::TRACK_W-1:0] out_track,
  output logic [flook_pkg::TAG_W-1:0]   out_tag
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Control state.
  logic          act_sel;
  logic [CW-1:0] act_cnt;
  logic [CW-1:0] pend_cnt;

  // Item and scan registers.
  logic                         op_q;
  logic [flook_pkg::TRACK_W-1:0] trk_q;
  logic [flook_pkg::TAG_W-1:0]   tag_q;
  logic [flook_pkg::TRACK_W-1:0] head_q;
  logic                         up_q;
  logic [CW-1:0]                idx;
  logic [CW-1:0]                sel;
  logic                         found;
  logic [flook_pkg::TRACK_W-1:0] best;
  logic [flook_pkg::TRACK_W-1:0] first_t;
  logic [flook_pkg::TRACK_W-1:0] last_t;
  logic [1:0]                   res_status;
  flook_pkg::entry_t            res_entry;

  flook_pkg::entry_t mem0 [QUEUE_DEPTH];
  flook_pkg::entry_t mem1 [QUEUE_DEPTH];
  flook_pkg::entry_t rdata0;
  flook_pkg::entry_t rdata1;
  flook_pkg::entry_t rdata;
  flook_pkg::entry_t wdata;
  logic [CW-1:0]     raddr;
  logic              we;
  logic              bank;

  logic [CW-1:0]                pick_idx;
  logic [flook_pkg::TRACK_W-1:0] t;
  logic [flook_pkg::TRACK_W-1:0] gap;
  logic                         hit;
  logic                         better;

  // Adds work on the pending bank, gets on the active bank.
  assign bank  = (op_q == flook_pkg::OP_GET) ? act_sel : ~act_sel;
  assign rdata = bank ? rdata1 : rdata0;
  assign t     = rdata.track;
  assign hit   = up_q ? (t >= head_q) : (t <= head_q);
  assign gap   = up_q ? (t - head_q) : (head_q - t);
  assign better = hit && (!found || (gap < best));

  always_comb begin
    if (up_q) begin
      pick_idx = (last_t > head_q) ? sel : (act_cnt - CW'(1));
    end else begin
      pick_idx = (first_t < head_q) ? sel : '0;
    end
  end

  always_comb begin
    raddr = idx;
    we    = 1'b0;
    wdata = rdata;
    case (ctl.cmd)
      flook_pkg::CMD_ADD_RD:   raddr = idx - CW'(1);
      flook_pkg::CMD_PICK:     raddr = pick_idx;
      flook_pkg::CMD_SH_RD:    raddr = idx + CW'(1);
      flook_pkg::CMD_ADD_MOVE: we = 1'b1;
      flook_pkg::CMD_SH_WR:    we = 1'b1;
      flook_pkg::CMD_ADD_PUT: begin
        we    = 1'b1;
        wdata = '{track: trk_q, tag: tag_q};
      end
      default: raddr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we && !bank) begin
      mem0[idx[IW-1:0]] <= wdata;
    end
    rdata0 <= mem0[raddr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we && bank) begin
      mem1[idx[IW-1:0]] <= wdata;
    end
    rdata1 <= mem1[raddr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_sel   <= 1'b0;
      act_cnt   <= '0;
      pend_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      case (ctl.cmd)
        flook_pkg::CMD_ADD_PUT: pend_cnt <= pend_cnt + CW'(1);
        flook_pkg::CMD_SWAP: begin
          act_sel  <= ~act_sel;
          act_cnt  <= pend_cnt;
          pend_cnt <= '0;
        end
        default: ;
      endcase
      if (ctl.shift_end) begin
        act_cnt <= act_cnt - CW'(1);
      end
      if (ctl.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      flook_pkg::CMD_LOAD: begin
        op_q      <= in_operation;
        trk_q     <= in_track;
        tag_q     <= in_tag;
        head_q    <= in_head;
        up_q      <= in_up;
        res_entry <= '0;
      end
      flook_pkg::CMD_DROP:     res_status <= flook_pkg::ST_DROPPED;
      flook_pkg::CMD_EMPTY:    res_status <= flook_pkg::ST_EMPTY;
      flook_pkg::CMD_ADD_PUT:  res_status <= flook_pkg::ST_ADDED;
      flook_pkg::CMD_ADD_INIT: idx <= pend_cnt;
      flook_pkg::CMD_ADD_MOVE: idx <= idx - CW'(1);
      flook_pkg::CMD_SWAP, flook_pkg::CMD_SCAN_INIT: begin
        idx   <= '0;
        found <= 1'b0;
      end
      flook_pkg::CMD_SCAN_EVAL: begin
        if (idx == '0) begin
          first_t <= t;
        end
        last_t <= t;
        if (better) begin
          found <= 1'b1;
          best  <= gap;
          sel   <= idx;
        end
        idx <= idx + CW'(1);
      end
      flook_pkg::CMD_PICK: idx <= pick_idx;
      flook_pkg::CMD_GRAB: begin
        res_status <= flook_pkg::ST_GRANTED;
        res_entry  <= rdata;
      end
      flook_pkg::CMD_SH_WR: idx <= idx + CW'(1);
      default: ;
    endcase
    if (ctl.finish) begin
      out_status <= res_status;
      out_track  <= res_entry.track;
      out_tag    <= res_entry.tag;
    end
  end

  assign stat.is_get     = (op_q == flook_pkg::OP_GET);
  assign stat.pend_full  = (pend_cnt == CW'(QUEUE_DEPTH));
  assign stat.pend_empty = (pend_cnt == '0);
  assign stat.act_empty  = (act_cnt == '0);
  assign stat.idx_zero   = (idx == '0);
  assign stat.move_up    = (rdata.track > trk_q);
  assign stat.scan_last  = ({1'b0, idx} + (CW+1)'(1) == {1'b0, act_cnt});
  assign stat.sh_done    = ({1'b0, idx} + (CW+1)'(1) >= {1'b0, act_cnt});
  assign stat.out_free   = !out_valid || out_ready;

endmodule
`default_nettype wire

>>> hw/rtl/flook_ctrl.sv
// Controller of the scheduler: sequences insert, scan, grant and close-up steps
// by commands to flook_datapath. Depends on flook_pkg.
`default_nettype none
module flook_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  flook_pkg::dp_stat_t stat,
  output flook_pkg::dp_ctl_t  ctl
);

  flook_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= flook_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctl.cmd       = flook_pkg::CMD_NONE;
    ctl.finish    = 1'b0;
    ctl.shift_end = 1'b0;
    in_ready      = 1'b0;
    case (state)
      flook_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cmd    = flook_pkg::CMD_LOAD;
          state_next = flook_pkg::S_DECIDE;
        end
      end
      flook_pkg::S_DECIDE: begin
        if (!stat.is_get) begin
          if (stat.pend_full) begin
            ctl.cmd    = flook_pkg::CMD_DROP;
            state_next = flook_pkg::S_FIN;
          end else begin
            ctl.cmd    = flook_pkg::CMD_ADD_INIT;
            state_next = flook_pkg::S_ADD_RD;
          end
        end else if (stat.act_empty && stat.pend_empty) begin
          ctl.cmd    = flook_pkg::CMD_EMPTY;
          state_next = flook_pkg::S_FIN;
        end else if (stat.act_empty) begin
          ctl.cmd    = flook_pkg::CMD_SWAP;
          state_next = flook_pkg::S_SCAN_RD;
        end else begin
          ctl.cmd    = flook_pkg::CMD_SCAN_INIT;
          state_next = flook_pkg::S_SCAN_RD;
        end
      end
      flook_pkg::S_ADD_RD: begin
        if (stat.idx_zero) begin
          ctl.cmd    = flook_pkg::CMD_ADD_PUT;
          state_next = flook_pkg::S_FIN;
        end else begin
          ctl.cmd    = flook_pkg::CMD_ADD_RD;
          state_next = flook_pkg::S_ADD_CMP;
        end
      end
      flook_pkg::S_ADD_CMP: begin
        // Entries above the new track move up one place; equal tracks stay ahead.
        if (stat.move_up) begin
          ctl.cmd    = flook_pkg::CMD_ADD_MOVE;
          state_next = flook_pkg::S_ADD_RD;
        end else begin
          ctl.cmd    = flook_pkg::CMD_ADD_PUT;
          state_next = flook_pkg::S_FIN;
        end
      end
      flook_pkg::S_SCAN_RD: begin
        ctl.cmd    = flook_pkg::CMD_SCAN_RD;
        state_next = flook_pkg::S_SCAN_EVAL;
      end
      flook_pkg::S_SCAN_EVAL: begin
        ctl.cmd    = flook_pkg::CMD_SCAN_EVAL;
        state_next = stat.scan_last ? flook_pkg::S_PICK : flook_pkg::S_SCAN_RD;
      end
      flook_pkg::S_PICK: begin
        ctl.cmd    = flook_pkg::CMD_PICK;
        state_next = flook_pkg::S_GRAB;
      end
      flook_pkg::S_GRAB: begin
        ctl.cmd    = flook_pkg::CMD_GRAB;
        state_next = flook_pkg::S_SHIFT;
      end
      flook_pkg::S_SHIFT: begin
        if (stat.sh_done) begin
          ctl.shift_end = 1'b1;
          state_next    = flook_pkg::S_FIN;
        end else begin
          ctl.cmd    = flook_pkg::CMD_SH_RD;
          state_next = flook_pkg::S_SHIFT_WR;
        end
      end
      flook_pkg::S_SHIFT_WR: begin
        ctl.cmd    = flook_pkg::CMD_SH_WR;
        state_next = flook_pkg::S_SHIFT;
      end
      flook_pkg::S_FIN: begin
        if (stat.out_free) begin
          ctl.finish = 1'b1;
          state_next = flook_pkg::S_IDLE;
        end
      end
      default: state_next = flook_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/frozen_look_scheduler_core.sv
// F-LOOK track request scheduler, top level.
// Channel req (sink) takes one item: operation 0 adds (track, tag) to the
// pending store, kept sorted by track; operation 1 grants the next request
// for head_position and direction_up, moving the pending store to the
// active side first when the active side is empty.
// Channel rsp (source) gives exactly one result item per request item:
// status, granted_track and granted_tag.
// One item is worked on at a time. An add moves each stored entry above the
// new track up one place and writes the new entry into the freed place; a full
// store drops the item and a get with both stores empty answers empty.
// A get scans every entry of the active bank, grants the chosen entry and then
// closes the gap by moving the entries above it down one place.
// The result sits in an output register; a new item is taken while it waits,
// but the next result waits there until the receiver takes the previous one.
// Synchronous reset empties both stores and clears the output valid flag.
`default_nettype none
module frozen_look_scheduler_core #(
  parameter int QUEUE_DEPTH = 32
) (
  input wire          clk,
  input wire          rst,
  flook_req_if.sink   req,
  flook_rsp_if.source rsp
);

  flook_pkg::dp_ctl_t  ctl;
  flook_pkg::dp_stat_t stat;

  flook_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  flook_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .in_operation (req.operation),
    .in_track     (req.track),
    .in_tag       (req.tag),
    .in_head      (req.head_position),
    .in_up        (req.direction_up),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_status   (rsp.status),
    .out_track    (rsp.granted_track),
    .out_tag      (rsp.granted_tag)
  );

  // An accepted item blocks the request channel until its result is built.
  assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while an item is in work");

  // Only a grant carries a track and a tag.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != flook_pkg::ST_GRANTED) |->
      (rsp.granted_track == '0) && (rsp.granted_tag == '0))
    else $error("non-grant result carries track or tag");

  // A result is loaded only when the output register is free.
  assert property (@(posedge clk) disable iff (rst)
    ctl.finish |-> stat.out_free)
    else $error("result overwrote an untaken result");

  // The pending store is never full and empty at once.
  assert property (@(posedge clk) disable iff (rst)
    !(stat.pend_full && stat.pend_empty))
    else $error("pending count inconsistent");

endmodule
`default_nettype wire
